/* sv/rs485ep_pkg.sv */
// rs485ep_pkg: shared types, codes and reset values for the rs485 encoder
// position reader; depends on nothing, used by the step logic and the top level
`timescale 1ns / 1ps

package rs485ep_pkg;

  // input command codes
  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_ZERO  = 3'd1;
  localparam logic [2:0] CMD_RESET = 3'd2;
  localparam logic [2:0] CMD_RX    = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_NODE_ADDRESS = 3'd0;
  localparam logic [2:0] REG_REPLY_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_TURNAROUND   = 3'd2;
  localparam logic [2:0] REG_RETRY_GAP    = 3'd3;
  localparam logic [2:0] REG_TRY_LIMIT    = 3'd4;

  // register reset values
  localparam logic [7:0]  NODE_ADDRESS_RST = 8'd84;
  localparam logic [15:0] REPLY_TIMEOUT_RST = 16'd2500;
  localparam logic [15:0] TURNAROUND_RST   = 16'd70;
  localparam logic [15:0] RETRY_GAP_RST    = 16'd150;
  localparam logic [7:0]  TRY_LIMIT_RST    = 8'd1;

  localparam logic [7:0] ZERO_FLAG  = 8'h02;
  localparam logic [7:0] RESET_FLAG = 8'h03;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TURN  = 3'd1,
    PH_WLOW  = 3'd2,
    PH_WHIGH = 3'd3,
    PH_GAP   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_ZERO  = 2'd1,
    OP_RESET = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    FAIL_NONE    = 2'd0,
    FAIL_TIMEOUT = 2'd1,
    FAIL_CHECK   = 2'd2
  } fail_t;

  typedef struct packed {
    logic [7:0]  node_address;
    logic [15:0] reply_timeout_ticks;
    logic [15:0] turnaround_ticks;
    logic [15:0] retry_gap_ticks;
    logic [7:0]  try_limit;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] tick_count;
    logic [7:0]  low_reply_byte;
    logic [7:0]  tries_used;
    op_t         operation_kind;
    logic [11:0] last_position;
  } ctl_state_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        driver_enable;
    logic        done_res;
    logic        success;
    logic [11:0] position;
    fail_t       fail_kind;
    logic        busy_res;
  } result_t;

  // odd parity check bits: bit 1 over odd position bits, bit 0 over even ones
  function automatic logic [1:0] check_bits(input logic [11:0] pos);
    logic ev;
    logic od;
    ev = pos[0] ^ pos[2] ^ pos[4] ^ pos[6] ^ pos[8] ^ pos[10];
    od = pos[1] ^ pos[3] ^ pos[5] ^ pos[7] ^ pos[9] ^ pos[11];
    return ~{od, ev};
  endfunction

endpackage

/* sv/rs485_encoder_position_reader.sv */
// rs485_encoder_position_reader: top level of the encoder read controller
// holds configuration, controller state and the result register; uses rs485ep_pkg
// and rs485ep_step
`timescale 1ns / 1ps

// Half-duplex controller for an addressed absolute encoder. Each input word is
// a command (read, zero, reset), a received bus byte or one time tick, and it
// yields exactly one result word that shows the bus outputs and status after
// that word. A word is handled combinationally: the state update and parity
// check sit between the controller state registers and the result register,
// so a new word is taken every cycle as long as the result register is empty
// or being drained in the same cycle (one word per cycle sustained). Timing is
// counted in input ticks, not clock cycles. Configuration registers are
// written through cfg_we/cfg_index/cfg_data and should only be changed while
// the controller is idle.
module rs485_encoder_position_reader (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [7:0]  rx_byte,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        driver_enable,
  output logic        done_res,
  output logic        success,
  output logic [11:0] position,
  output logic [1:0]  fail_kind,
  output logic        busy_res
);
  import rs485ep_pkg::*;

  cfg_t       cfg;
  ctl_state_t state;
  ctl_state_t state_next;
  result_t    res_next;
  result_t    res;
  logic       accept;

  // result register frees up when empty or taken this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_address        <= NODE_ADDRESS_RST;
      cfg.reply_timeout_ticks <= REPLY_TIMEOUT_RST;
      cfg.turnaround_ticks    <= TURNAROUND_RST;
      cfg.retry_gap_ticks     <= RETRY_GAP_RST;
      cfg.try_limit           <= TRY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_ADDRESS:  cfg.node_address        <= cfg_data[7:0];
        REG_REPLY_TIMEOUT: cfg.reply_timeout_ticks <= cfg_data;
        REG_TURNAROUND:    cfg.turnaround_ticks    <= cfg_data;
        REG_RETRY_GAP:     cfg.retry_gap_ticks     <= cfg_data;
        REG_TRY_LIMIT:     cfg.try_limit           <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // all per-word logic lives in the step block
  rs485ep_step u_step (
    .cfg     (cfg),
    .cur     (state),
    .command (command),
    .rx_byte (rx_byte),
    .nxt     (state_next),
    .res     (res_next)
  );

  // controller state advances only on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= PH_IDLE;
      state.tick_count     <= 16'd0;
      state.low_reply_byte <= 8'd0;
      state.tries_used     <= 8'd0;
      state.operation_kind <= OP_READ;
      state.last_position  <= 12'd0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // result register: valid is control, payload loads on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign tx_valid      = res.tx_valid;
  assign tx_byte       = res.tx_byte;
  assign driver_enable = res.driver_enable;
  assign done_res      = res.done_res;
  assign success       = res.success;
  assign position      = res.position;
  assign fail_kind     = res.fail_kind;
  assign busy_res      = res.busy_res;

  // waiting for reply bytes only ever happens during a read
  assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_WLOW || state.phase == PH_WHIGH) |-> state.operation_kind == OP_READ)
    else $error("reply wait outside a read");

  // an accepted word always produces a result word
  assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  // a finished operation is either a success or carries a fail kind
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (success != (fail_kind != FAIL_NONE)))
    else $error("finish without exactly one of success or fail kind");

  // the result reflects the controller state it was produced with
  assert property (@(posedge clk) disable iff (rst)
    $past(accept) |-> (busy_res == (state.phase != PH_IDLE)
                       && position == state.last_position))
    else $error("result out of step with controller state");

endmodule

/* sv/rs485ep_step.sv */
// rs485ep_step: next-state and result logic for one input word
// depends on rs485ep_pkg
`timescale 1ns / 1ps

module rs485ep_step (
  input  rs485ep_pkg::cfg_t       cfg,
  input  rs485ep_pkg::ctl_state_t cur,
  input  logic [2:0]              command,
  input  logic [7:0]              rx_byte,
  output rs485ep_pkg::ctl_state_t nxt,
  output rs485ep_pkg::result_t    res
);
  import rs485ep_pkg::*;

  logic        do_fail;
  logic        do_enter;
  logic        do_send;
  fail_t       fail_k;
  logic [15:0] tick_inc;
  logic [7:0]  tries_inc;
  logic [11:0] rx_pos;
  logic [7:0]  cmd_byte;

  assign tick_inc = cur.tick_count + 16'd1;
  assign rx_pos   = {rx_byte[5:0], cur.low_reply_byte[7:2]};

  always_comb begin
    nxt       = cur;
    res       = '0;
    do_fail   = 1'b0;
    do_enter  = 1'b0;
    do_send   = 1'b0;
    fail_k    = FAIL_NONE;
    tries_inc = 8'd0;
    cmd_byte  = 8'd0;

    case (command)
      CMD_READ, CMD_ZERO, CMD_RESET: begin
        if (cur.phase == PH_IDLE) begin
          nxt.operation_kind = op_t'(command[1:0]);
          nxt.tries_used     = 8'd0;
          do_enter           = 1'b1;
        end
      end
      CMD_RX: begin
        if (cur.phase == PH_WLOW) begin
          nxt.low_reply_byte = rx_byte;
          nxt.tick_count     = 16'd0;
          nxt.phase          = PH_WHIGH;
        end else if (cur.phase == PH_WHIGH) begin
          if (check_bits(rx_pos) != rx_byte[7:6]) begin
            do_fail = 1'b1;
            fail_k  = FAIL_CHECK;
          end else begin
            nxt.last_position = rx_pos;
            nxt.phase         = PH_IDLE;
            nxt.tick_count    = 16'd0;
            res.done_res      = 1'b1;
            res.success       = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (cur.phase == PH_TURN) begin
          nxt.tick_count = tick_inc;
          do_send        = (tick_inc >= cfg.turnaround_ticks);
        end else if (cur.phase == PH_WLOW || cur.phase == PH_WHIGH) begin
          if (cur.tick_count >= cfg.reply_timeout_ticks) begin
            do_fail = 1'b1;
            fail_k  = FAIL_TIMEOUT;
          end else begin
            nxt.tick_count = tick_inc;
          end
        end else if (cur.phase == PH_GAP) begin
          nxt.tick_count = tick_inc;
          do_enter       = (tick_inc >= cfg.retry_gap_ticks);
        end
      end
      default: begin
      end
    endcase

    // failed try: report on the last one, else gap or retry at once
    if (do_fail) begin
      tries_inc      = cur.tries_used + 8'd1;
      nxt.tries_used = tries_inc;
      nxt.tick_count = 16'd0;
      if (tries_inc >= cfg.try_limit) begin
        nxt.phase     = PH_IDLE;
        res.done_res  = 1'b1;
        res.fail_kind = fail_k;
      end else if (cfg.retry_gap_ticks == 16'd0) begin
        do_enter = 1'b1;
      end else begin
        nxt.phase = PH_GAP;
      end
    end

    if (do_enter) begin
      nxt.phase      = PH_TURN;
      nxt.tick_count = 16'd0;
      if (cfg.turnaround_ticks == 16'd0) begin
        do_send = 1'b1;
      end
    end

    if (do_send) begin
      cmd_byte = cfg.node_address;
      if (nxt.operation_kind == OP_ZERO) begin
        cmd_byte = cmd_byte | ZERO_FLAG;
      end else if (nxt.operation_kind == OP_RESET) begin
        cmd_byte = cmd_byte | RESET_FLAG;
      end
      res.tx_valid   = 1'b1;
      res.tx_byte    = cmd_byte;
      nxt.tick_count = 16'd0;
      if (nxt.operation_kind == OP_READ) begin
        nxt.phase = PH_WLOW;
      end else begin
        nxt.phase    = PH_IDLE;
        res.done_res = 1'b1;
        res.success  = 1'b1;
      end
    end

    res.driver_enable = !(nxt.phase == PH_WLOW || nxt.phase == PH_WHIGH);
    res.busy_res      = (nxt.phase != PH_IDLE);
    res.position      = nxt.last_position;
  end

endmodule

/* tb/sv/rs485ep_checker.sv */
// rs485ep_checker: predicts each result word of the encoder read controller
// from the accepted input words and register writes, and compares; uses rs485ep_pkg
`timescale 1ns / 1ps

module rs485ep_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  command,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        tx_valid,
  input  logic [7:0]  tx_byte,
  input  logic        driver_enable,
  input  logic        done_res,
  input  logic        success,
  input  logic [11:0] position,
  input  logic [1:0]  fail_kind,
  input  logic        busy_res,
  output int unsigned fault_count,
  output int unsigned words_due,
  output logic        ctl_busy
);
  import rs485ep_pkg::*;

  cfg_t        regs;
  phase_t      ph;
  logic [15:0] ticks;
  logic [7:0]  low_byte;
  logic [7:0]  tries;
  op_t         op;
  logic [11:0] last_pos;
  result_t     step_out;
  result_t     due_results[$];
  int unsigned faults;

  assign fault_count = faults;

  function automatic void send_frame();
    logic [7:0] b;
    b = regs.node_address;
    if (op == OP_ZERO) begin
      b = b | ZERO_FLAG;
    end else if (op == OP_RESET) begin
      b = b | RESET_FLAG;
    end
    step_out.tx_valid = 1'b1;
    step_out.tx_byte  = b;
    ticks = '0;
    if (op == OP_READ) begin
      ph = PH_WLOW;
    end else begin
      ph = PH_IDLE;
      step_out.done_res = 1'b1;
      step_out.success  = 1'b1;
    end
  endfunction

  function automatic void start_turnaround();
    ph = PH_TURN;
    ticks = '0;
    if (regs.turnaround_ticks == 16'd0) send_frame();
  endfunction

  function automatic void try_failed(fail_t why);
    tries = tries + 8'd1;
    ticks = '0;
    if (tries >= regs.try_limit) begin
      ph = PH_IDLE;
      step_out.done_res  = 1'b1;
      step_out.success   = 1'b0;
      step_out.fail_kind = why;
    end else if (regs.retry_gap_ticks == 16'd0) begin
      start_turnaround();
    end else begin
      ph = PH_GAP;
    end
  endfunction

  // odd parity: top bit over odd position bits, next bit over even ones
  function automatic void reply_done(logic [7:0] hi);
    logic [15:0] w;
    logic [11:0] p;
    logic [1:0]  want;
    w = {hi, low_byte};
    p = w[13:2];
    want = ~{^(p & 12'hAAA), ^(p & 12'h555)};
    if (want != w[15:14]) begin
      try_failed(FAIL_CHECK);
    end else begin
      last_pos = p;
      ph = PH_IDLE;
      ticks = '0;
      step_out.done_res = 1'b1;
      step_out.success  = 1'b1;
    end
  endfunction

  function automatic result_t advance_controller(logic [2:0] cmd, logic [7:0] rx);
    step_out = '0;
    case (cmd)
      CMD_READ, CMD_ZERO, CMD_RESET: begin
        if (ph == PH_IDLE) begin
          op = op_t'(cmd[1:0]);
          tries = '0;
          start_turnaround();
        end
      end
      CMD_RX: begin
        if (ph == PH_WLOW) begin
          low_byte = rx;
          ticks = '0;
          ph = PH_WHIGH;
        end else if (ph == PH_WHIGH) begin
          reply_done(rx);
        end
      end
      CMD_TICK: begin
        if (ph == PH_TURN) begin
          ticks = ticks + 16'd1;
          if (ticks >= regs.turnaround_ticks) send_frame();
        end else if (ph == PH_WLOW || ph == PH_WHIGH) begin
          if (ticks >= regs.reply_timeout_ticks) try_failed(FAIL_TIMEOUT);
          else ticks = ticks + 16'd1;
        end else if (ph == PH_GAP) begin
          ticks = ticks + 16'd1;
          if (ticks >= regs.retry_gap_ticks) start_turnaround();
        end
      end
      default: ;
    endcase
    step_out.driver_enable = !(ph == PH_WLOW || ph == PH_WHIGH);
    step_out.position      = last_pos;
    step_out.busy_res      = (ph != PH_IDLE);
    return step_out;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      regs.node_address        = NODE_ADDRESS_RST;
      regs.reply_timeout_ticks = REPLY_TIMEOUT_RST;
      regs.turnaround_ticks    = TURNAROUND_RST;
      regs.retry_gap_ticks     = RETRY_GAP_RST;
      regs.try_limit           = TRY_LIMIT_RST;
      ph       = PH_IDLE;
      ticks    = '0;
      low_byte = '0;
      tries    = '0;
      op       = OP_READ;
      last_pos = '0;
      due_results.delete();
      faults   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_ADDRESS:  regs.node_address        = cfg_data[7:0];
          REG_REPLY_TIMEOUT: regs.reply_timeout_ticks = cfg_data;
          REG_TURNAROUND:    regs.turnaround_ticks    = cfg_data;
          REG_RETRY_GAP:     regs.retry_gap_ticks     = cfg_data;
          REG_TRY_LIMIT:     regs.try_limit           = cfg_data[7:0];
          default: ;
        endcase
      end
      // results leave before new words are predicted, as each result is registered
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result word with no expectation waiting");
          faults++;
        end else begin
          want = due_results.pop_front();
          compare_field("tx_valid", want.tx_valid, tx_valid);
          compare_field("tx_byte", want.tx_byte, tx_byte);
          compare_field("driver_enable", want.driver_enable, driver_enable);
          compare_field("done_res", want.done_res, done_res);
          compare_field("success", want.success, success);
          compare_field("position", want.position, position);
          compare_field("fail_kind", int'(want.fail_kind), fail_kind);
          compare_field("busy_res", want.busy_res, busy_res);
        end
      end
      if (in_valid && in_ready) due_results.push_back(advance_controller(command, rx_byte));
    end
    words_due <= due_results.size();
    ctl_busy  <= (ph != PH_IDLE);
  end

endmodule

/* tb/sv/tb_rs485_encoder_position_reader.sv */
// tb_rs485_encoder_position_reader: stimulus and verdict for the encoder read
// controller; depends on rs485ep_pkg, rs485ep_checker and the block's rtl
`timescale 1ns / 1ps

module tb_rs485_encoder_position_reader;
  import rs485ep_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  command;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        driver_enable;
  logic        done_res;
  logic        success;
  logic [11:0] position;
  logic [1:0]  fail_kind;
  logic        busy_res;

  int unsigned fault_count;
  int unsigned words_due;
  logic        ctl_busy;

  // settings currently loaded, used to shape well-formed tick counts
  cfg_t        settings;
  // when set, neither side inserts idle cycles
  bit          quiet;
  int unsigned words_sent;
  int unsigned ops_run;
  int unsigned settings_used;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  rs485_encoder_position_reader dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .driver_enable(driver_enable),
    .done_res     (done_res),
    .success      (success),
    .position     (position),
    .fail_kind    (fail_kind),
    .busy_res     (busy_res)
  );

  rs485ep_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .driver_enable(driver_enable),
    .done_res     (done_res),
    .success      (success),
    .position     (position),
    .fail_kind    (fail_kind),
    .busy_res     (busy_res),
    .fault_count  (fault_count),
    .words_due    (words_due),
    .ctl_busy     (ctl_busy)
  );

  // hand one word to the block; valid stays high into the next word when no gap is drawn
  task automatic push_word(logic [2:0] cmd, logic [7:0] rx, bit counted);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    rx_byte  <= rx;
    do @(posedge clk); while (!in_ready);
    if (counted) words_sent++;
  endtask

  // let every predicted result drain, then give the result register time to empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (3) @(posedge clk);
  endtask

  // push the controller back to idle: ticks move turnaround and gap, bytes end a read
  task automatic drain();
    settle();
    while (ctl_busy) begin
      push_word(CMD_TICK, 8'($urandom), 1'b0);
      push_word(CMD_RX, 8'($urandom), 1'b0);
      settle();
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // only called with the controller idle and nothing in flight
  task automatic load_settings(cfg_t c);
    settings = c;
    write_reg(REG_NODE_ADDRESS, {8'd0, c.node_address});
    write_reg(REG_REPLY_TIMEOUT, c.reply_timeout_ticks);
    write_reg(REG_TURNAROUND, c.turnaround_ticks);
    write_reg(REG_RETRY_GAP, c.retry_gap_ticks);
    write_reg(REG_TRY_LIMIT, {8'd0, c.try_limit});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // reply word with random position and dropped bits; bad replies flip check bits
  function automatic logic [15:0] reply_word(bit good);
    logic [11:0] p;
    logic [1:0]  chk;
    p = 12'($urandom);
    chk = ~{^(p & 12'hAAA), ^(p & 12'h555)};
    if (!good) chk = chk ^ 2'($urandom_range(1, 3));
    return {chk, p, 2'($urandom)};
  endfunction

  // a word the controller ignores: a command while busy, an undefined code, a stray byte
  task automatic push_noise(bit allow_byte);
    case ($urandom_range(0, allow_byte ? 2 : 1))
      0: push_word(3'($urandom_range(0, 2)), 8'($urandom), 1'b0);
      1: push_word(3'($urandom_range(5, 7)), 8'($urandom), 1'b0);
      default: push_word(CMD_RX, 8'($urandom), 1'b0);
    endcase
  endtask

  // n ticks; noise 0 none, 1 anything ignored, 2 ignored but no bytes (reply wait)
  task automatic spin_ticks(int unsigned n, int noise);
    for (int unsigned i = 0; i < n; i++) begin
      if (noise != 0 && $urandom_range(0, 7) == 0) push_noise(noise == 1);
      push_word(CMD_TICK, 8'($urandom), 1'b1);
    end
  endtask

  // one well-formed operation from idle back to idle; pick 3 draws the kind
  task automatic run_operation(int pick);
    logic [2:0]  cmd;
    int unsigned limit;
    int unsigned outcome;
    int unsigned cap;
    int unsigned tmo;
    logic [15:0] w;
    case (pick)
      0: cmd = CMD_READ;
      1: cmd = CMD_ZERO;
      2: cmd = CMD_RESET;
      default: cmd = ($urandom_range(0, 9) < 7) ? CMD_READ :
                     ($urandom_range(0, 1) ? CMD_ZERO : CMD_RESET);
    endcase
    ops_run++;
    tmo = settings.reply_timeout_ticks;
    cap = (tmo < 3) ? tmo : 3;
    push_word(cmd, 8'($urandom), 1'b1);
    spin_ticks(settings.turnaround_ticks, 1);
    if (cmd == CMD_READ) begin
      limit = (settings.try_limit == 0) ? 1 : settings.try_limit;
      for (int unsigned t = 0; t < limit; t++) begin
        // 0..5 good reply, 6..7 check mismatch, 8..9 timeout where affordable
        outcome = $urandom_range(0, 9);
        if (outcome >= 8 && tmo > 40) outcome = 6;
        w = reply_word(outcome < 6);
        if (outcome >= 8 && $urandom_range(0, 1)) begin
          spin_ticks(tmo + 1, 2);
        end else begin
          spin_ticks($urandom_range(0, cap), 2);
          push_word(CMD_RX, w[7:0], 1'b1);
          if (outcome >= 8) begin
            spin_ticks(tmo + 1, 2);
          end else begin
            spin_ticks($urandom_range(0, cap), 2);
            push_word(CMD_RX, w[15:8], 1'b1);
          end
        end
        if (outcome < 6) break;
        // retry: gap then a fresh turnaround, unless this was the last try
        if (t + 1 < limit) begin
          spin_ticks(settings.retry_gap_ticks, 1);
          spin_ticks(settings.turnaround_ticks, 1);
        end
      end
    end
  endtask

  // output side: each result word waits a random stall before ready goes high
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    cfg_t c;
    int unsigned round;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_NODE_ADDRESS;
    cfg_data  = '0;
    in_valid  = 1'b0;
    command   = CMD_TICK;
    rx_byte   = '0;
    quiet     = 1'b0;
    words_sent = 0;
    ops_run    = 0;
    settings_used = 0;
    settings = cfg_t'{NODE_ADDRESS_RST, REPLY_TIMEOUT_RST, TURNAROUND_RST,
                      RETRY_GAP_RST, TRY_LIMIT_RST};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register values straight out of reset: long turnaround, single try
    run_operation(0);
    run_operation(3);
    drain();

    // directed: every delay zero and a zero try limit
    load_settings(cfg_t'{8'h00, 16'd0, 16'd0, 16'd0, 8'd0});
    push_word(CMD_TICK, 8'h00, 1'b1);      // idle tick does nothing
    push_word(CMD_RX, 8'hFF, 1'b1);        // stray byte while idle
    push_word(3'd5, 8'hFF, 1'b1);          // undefined codes
    push_word(3'd6, 8'h00, 1'b1);
    push_word(3'd7, 8'h00, 1'b1);
    push_word(CMD_READ, 8'h00, 1'b1);      // zero turnaround sends at once
    push_word(CMD_READ, 8'h00, 1'b1);      // busy commands ignored
    push_word(CMD_ZERO, 8'h00, 1'b1);
    push_word(CMD_TICK, 8'h00, 1'b1);      // zero timeout fails, reported at once
    push_word(CMD_ZERO, 8'h00, 1'b1);      // address|2, done in the same word
    push_word(CMD_RESET, 8'h00, 1'b1);     // address|3
    settle();

    // directed: check mismatch with immediate retry, then timeout on the last try
    load_settings(cfg_t'{8'hFC, 16'd1, 16'd1, 16'd0, 8'd2});
    push_word(CMD_READ, 8'h00, 1'b1);
    push_word(CMD_RX, 8'h00, 1'b1);        // stray byte in turnaround
    push_word(CMD_TICK, 8'h00, 1'b1);
    push_word(CMD_RX, 8'h00, 1'b1);
    push_word(CMD_RX, 8'h00, 1'b1);        // bad check bits, zero gap
    push_word(CMD_TICK, 8'h00, 1'b1);
    push_word(CMD_RX, 8'hFF, 1'b1);
    push_word(CMD_TICK, 8'h00, 1'b1);
    push_word(CMD_TICK, 8'h00, 1'b1);      // high byte timeout ends it
    settle();

    // directed: timeout, byte dropped in the retry gap, full-scale position
    load_settings(cfg_t'{8'h54, 16'd1, 16'd1, 16'd2, 8'd2});
    push_word(CMD_READ, 8'h00, 1'b1);
    push_word(CMD_TICK, 8'h00, 1'b1);
    push_word(CMD_TICK, 8'h00, 1'b1);
    push_word(CMD_TICK, 8'h00, 1'b1);
    push_word(CMD_RX, 8'h5A, 1'b1);
    push_word(CMD_TICK, 8'h00, 1'b1);
    push_word(CMD_TICK, 8'h00, 1'b1);
    push_word(CMD_TICK, 8'h00, 1'b1);
    push_word(CMD_RX, 8'hFF, 1'b1);
    push_word(CMD_RX, 8'hFF, 1'b1);
    settle();

    // random phases: new settings each round, mostly short delays
    round = 0;
    while (words_sent < 500) begin
      c.node_address = 8'($urandom);
      case ($urandom_range(0, 7))
        0: c.reply_timeout_ticks = 16'd0;
        1: c.reply_timeout_ticks = 16'd1;
        2: c.reply_timeout_ticks = 16'hFFFF;
        default: c.reply_timeout_ticks = 16'($urandom_range(2, 8));
      endcase
      c.turnaround_ticks = 16'($urandom_range(0, 4));
      c.retry_gap_ticks  = 16'($urandom_range(0, 4));
      c.try_limit = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 4));
      load_settings(c);
      quiet = (round % 4 == 3);
      for (int k = 0; k < 6; k++) begin
        // an occasional fully random word between operations
        if ($urandom_range(0, 9) == 0) push_word(3'($urandom), 8'($urandom), 1'b0);
        run_operation(3);
      end
      drain();
      round++;
    end

    // top of address, timeout and try limit ranges, short delays, no idling
    quiet = 1'b1;
    load_settings(cfg_t'{8'hFF, 16'hFFFF, 16'd2, 16'd1, 8'd255});
    run_operation(0);
    drain();
    quiet = 1'b0;

    settle();
    $display("covered %0d counted input words, %0d operations, %0d register settings",
             words_sent, ops_run, settings_used);
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog well past the slowest legal run
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
sv/rs485ep_pkg.sv
sv/rs485ep_step.sv
sv/rs485_encoder_position_reader.sv
tb/sv/rs485ep_checker.sv
tb/sv/tb_rs485_encoder_position_reader.sv
